/* hdl/tgarle_pkg.sv */
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the TGA run-length unpacker.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int MAX_UNIT_BYTES   = 4;
  localparam int PIXEL_COUNT_BITS = 24;

  localparam int UNIT_W  = 8 * MAX_UNIT_BYTES;
  localparam int IDX_W   = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;
  localparam int USIZE_W = 3;
  localparam int PIX_W   = 25;
  localparam int SKIP_W  = 19;
  localparam int RUN_W   = 8;
  localparam int STAT_W  = 3;

  localparam logic [PIX_W-1:0] PIX_CAP = PIX_W'(1) << PIXEL_COUNT_BITS;

  localparam logic [7:0] RUN_MASK   = 8'h7f;
  localparam logic [7:0] REPEAT_BIT = 8'h80;

  // result status codes
  localparam logic [STAT_W-1:0] ST_PIXEL      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EARLY_END  = 3'd1;
  localparam logic [STAT_W-1:0] ST_RUN_PAST   = 3'd2;
  localparam logic [STAT_W-1:0] ST_MID_RUN    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MID_PACKET = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BPP   = 2'd0;
  localparam logic [1:0] CFG_RLE   = 2'd1;
  localparam logic [1:0] CFG_TOTAL = 2'd2;
  localparam logic [1:0] CFG_SKIP  = 2'd3;

  typedef enum logic [2:0] {
    PH_START,
    PH_SKIP,
    PH_HEADER,
    PH_RAW,
    PH_REPEAT,
    PH_LITERAL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [USIZE_W-1:0] bytes_per_pixel;
    logic               run_length_mode;
    logic [PIX_W-1:0]   pixel_total;
    logic [SKIP_W-1:0]  skip_bytes;
  } cfg_t;

  typedef struct packed {
    logic [UNIT_W-1:0] pixel_value;
    logic [RUN_W-1:0]  repeat_count;
    logic [STAT_W-1:0] status;
    logic              last;
  } result_t;

endpackage

/* hdl/tgarle_core.sv */
// ----------------------------------------------------------------------------
// tgarle_core
// Byte-level decode state: header skip, packet parsing and pixel assembly.
// Gives up to two results for each accepted byte, first one first.
// ----------------------------------------------------------------------------
module tgarle_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic                       end_of_file,
  input  tgarle_pkg::cfg_t           cfg,
  output logic [1:0]                 push_cnt,
  output tgarle_pkg::result_t        res_first,
  output tgarle_pkg::result_t        res_second
);

  tgarle_pkg::phase_t                   phase;
  logic [tgarle_pkg::SKIP_W-1:0]        skip_left;
  logic [tgarle_pkg::PIX_W-1:0]         pixels_left;
  logic [tgarle_pkg::RUN_W-1:0]         packet_left;
  logic [tgarle_pkg::UNIT_W-1:0]        unit_buffer;
  logic [tgarle_pkg::IDX_W-1:0]         unit_idx;

  tgarle_pkg::phase_t                   phase_next;
  logic [tgarle_pkg::SKIP_W-1:0]        skip_left_next;
  logic [tgarle_pkg::PIX_W-1:0]         pixels_left_next;
  logic [tgarle_pkg::RUN_W-1:0]         packet_left_next;
  logic [tgarle_pkg::UNIT_W-1:0]        unit_buffer_next;
  logic [tgarle_pkg::IDX_W-1:0]         unit_idx_next;

  // state after picture start
  tgarle_pkg::phase_t                   st_phase;
  logic [tgarle_pkg::SKIP_W-1:0]        st_skip;
  logic [tgarle_pkg::PIX_W-1:0]         st_pix;
  logic [tgarle_pkg::RUN_W-1:0]         st_pkt;
  logic [tgarle_pkg::UNIT_W-1:0]        st_buf;
  logic [tgarle_pkg::IDX_W-1:0]         st_idx;

  // state after the byte's work, before end of file
  tgarle_pkg::phase_t                   w_phase;
  logic [tgarle_pkg::SKIP_W-1:0]        w_skip;
  logic [tgarle_pkg::PIX_W-1:0]         w_pix;
  logic [tgarle_pkg::RUN_W-1:0]         w_pkt;
  logic [tgarle_pkg::UNIT_W-1:0]        w_buf;
  logic [tgarle_pkg::IDX_W-1:0]         w_idx;
  logic                                 w_res_valid;
  tgarle_pkg::result_t                  w_res;

  logic                                 eof_valid;
  tgarle_pkg::result_t                  eof_res;

  logic [tgarle_pkg::USIZE_W-1:0]       unit_size;
  logic [tgarle_pkg::PIX_W-1:0]         total_sat;
  logic [tgarle_pkg::UNIT_W-1:0]        merged;
  logic [tgarle_pkg::USIZE_W-1:0]       idx_inc;
  logic [tgarle_pkg::RUN_W-1:0]         run;
  logic [tgarle_pkg::RUN_W-1:0]         rep;
  logic [tgarle_pkg::RUN_W-1:0]         pkt_after;
  logic [tgarle_pkg::PIX_W-1:0]         pix_after;
  logic [tgarle_pkg::SKIP_W-1:0]        skip_dec;

  function automatic tgarle_pkg::phase_t data_phase(input logic empty, input logic rle);
    tgarle_pkg::phase_t ph;
    if (empty) begin
      ph = tgarle_pkg::PH_DONE;
    end else if (rle) begin
      ph = tgarle_pkg::PH_HEADER;
    end else begin
      ph = tgarle_pkg::PH_RAW;
    end
    return ph;
  endfunction

  always_comb begin
    if (cfg.bytes_per_pixel == '0) begin
      unit_size = tgarle_pkg::USIZE_W'(1);
    end else if (cfg.bytes_per_pixel > tgarle_pkg::USIZE_W'(tgarle_pkg::MAX_UNIT_BYTES)) begin
      unit_size = tgarle_pkg::USIZE_W'(tgarle_pkg::MAX_UNIT_BYTES);
    end else begin
      unit_size = cfg.bytes_per_pixel;
    end
    total_sat = (cfg.pixel_total > tgarle_pkg::PIX_CAP) ? tgarle_pkg::PIX_CAP
                                                        : cfg.pixel_total;
  end

  // picture start: load counters on the first byte of a file
  always_comb begin
    st_phase = phase;
    st_skip  = skip_left;
    st_pix   = pixels_left;
    st_pkt   = packet_left;
    st_buf   = unit_buffer;
    st_idx   = unit_idx;
    if (phase == tgarle_pkg::PH_START) begin
      st_pix = total_sat;
      st_skip = cfg.skip_bytes;
      st_pkt = '0;
      st_buf = '0;
      st_idx = '0;
      if (cfg.skip_bytes != '0) begin
        st_phase = tgarle_pkg::PH_SKIP;
      end else begin
        st_phase = data_phase(total_sat == '0, cfg.run_length_mode);
      end
    end
  end

  // per-byte work
  always_comb begin
    merged = st_buf;
    for (int k = 0; k < tgarle_pkg::MAX_UNIT_BYTES; k++) begin
      if (st_idx == tgarle_pkg::IDX_W'(k)) begin
        merged[8*k +: 8] = data_byte;
      end
    end
    idx_inc   = tgarle_pkg::USIZE_W'(st_idx) + tgarle_pkg::USIZE_W'(1);
    run       = (data_byte & tgarle_pkg::RUN_MASK) + tgarle_pkg::RUN_W'(1);
    skip_dec  = st_skip - tgarle_pkg::SKIP_W'(1);
    rep       = (st_phase == tgarle_pkg::PH_REPEAT) ? st_pkt : tgarle_pkg::RUN_W'(1);
    pix_after = st_pix - tgarle_pkg::PIX_W'(rep);
    pkt_after = st_pkt;
    if (st_phase == tgarle_pkg::PH_REPEAT) begin
      pkt_after = '0;
    end else if (st_phase == tgarle_pkg::PH_LITERAL) begin
      pkt_after = st_pkt - tgarle_pkg::RUN_W'(1);
    end

    w_phase     = st_phase;
    w_skip      = st_skip;
    w_pix       = st_pix;
    w_pkt       = st_pkt;
    w_buf       = st_buf;
    w_idx       = st_idx;
    w_res_valid = 1'b0;
    w_res       = '0;

    case (st_phase)
      tgarle_pkg::PH_SKIP: begin
        w_skip = skip_dec;
        if (skip_dec == '0) begin
          w_buf = '0;
          w_idx = '0;
          w_phase = data_phase(st_pix == '0, cfg.run_length_mode);
        end
      end
      tgarle_pkg::PH_HEADER: begin
        if (tgarle_pkg::PIX_W'(run) > st_pix) begin
          w_res_valid = 1'b1;
          w_res.status = tgarle_pkg::ST_RUN_PAST;
          w_res.last = 1'b1;
          w_phase = tgarle_pkg::PH_DONE;
        end else begin
          w_pkt = run;
          w_buf = '0;
          w_idx = '0;
          w_phase = ((data_byte & tgarle_pkg::REPEAT_BIT) != '0) ? tgarle_pkg::PH_REPEAT
                                                                : tgarle_pkg::PH_LITERAL;
        end
      end
      tgarle_pkg::PH_RAW, tgarle_pkg::PH_REPEAT, tgarle_pkg::PH_LITERAL: begin
        if (idx_inc >= unit_size) begin
          w_buf = '0;
          w_idx = '0;
          w_pkt = pkt_after;
          w_pix = pix_after;
          w_res_valid = 1'b1;
          w_res.pixel_value = merged;
          w_res.repeat_count = rep;
          w_res.status = tgarle_pkg::ST_PIXEL;
          w_res.last = (pix_after == '0);
          if (pix_after == '0) begin
            w_phase = tgarle_pkg::PH_DONE;
          end else if (st_phase == tgarle_pkg::PH_REPEAT) begin
            w_phase = tgarle_pkg::PH_HEADER;
          end else if (st_phase == tgarle_pkg::PH_LITERAL && pkt_after == '0) begin
            w_phase = tgarle_pkg::PH_HEADER;
          end
        end else begin
          w_buf = merged;
          w_idx = idx_inc[tgarle_pkg::IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // end of file check on the phase left by this byte
  always_comb begin
    eof_res = '0;
    eof_res.last = 1'b1;
    eof_valid = 1'b0;
    unique case (w_phase)
      tgarle_pkg::PH_SKIP, tgarle_pkg::PH_HEADER, tgarle_pkg::PH_RAW: begin
        eof_valid = end_of_file;
        eof_res.status = tgarle_pkg::ST_EARLY_END;
      end
      tgarle_pkg::PH_REPEAT: begin
        eof_valid = end_of_file;
        eof_res.status = tgarle_pkg::ST_MID_RUN;
      end
      tgarle_pkg::PH_LITERAL: begin
        eof_valid = end_of_file;
        eof_res.status = tgarle_pkg::ST_MID_PACKET;
      end
      default: begin
        eof_valid = 1'b0;
      end
    endcase
  end

  // outputs: compact the two result slots
  always_comb begin
    res_first  = w_res_valid ? w_res : eof_res;
    res_second = eof_res;
    push_cnt   = '0;
    if (accept) begin
      push_cnt = 2'(w_res_valid) + 2'(eof_valid);
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    skip_left_next   = skip_left;
    pixels_left_next = pixels_left;
    packet_left_next = packet_left;
    unit_buffer_next = unit_buffer;
    unit_idx_next    = unit_idx;
    if (accept) begin
      if (end_of_file) begin
        phase_next       = tgarle_pkg::PH_START;
        skip_left_next   = '0;
        pixels_left_next = '0;
        packet_left_next = '0;
        unit_buffer_next = '0;
        unit_idx_next    = '0;
      end else begin
        phase_next       = w_phase;
        skip_left_next   = w_skip;
        pixels_left_next = w_pix;
        packet_left_next = w_pkt;
        unit_buffer_next = w_buf;
        unit_idx_next    = w_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= tgarle_pkg::PH_START;
      skip_left   <= '0;
      pixels_left <= '0;
      packet_left <= '0;
      unit_buffer <= '0;
      unit_idx    <= '0;
    end else begin
      phase       <= phase_next;
      skip_left   <= skip_left_next;
      pixels_left <= pixels_left_next;
      packet_left <= packet_left_next;
      unit_buffer <= unit_buffer_next;
      unit_idx    <= unit_idx_next;
    end
  end

endmodule

/* hdl/tgarle_outq.sv */
// ----------------------------------------------------------------------------
// tgarle_outq
// Four-entry result queue: takes up to two results a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module tgarle_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            push_cnt,
  input  tgarle_pkg::result_t   push_first,
  input  tgarle_pkg::result_t   push_second,
  output logic                  full2,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tgarle_pkg::result_t   out_res
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  tgarle_pkg::result_t      mem [DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [PTR_W:0]           count;
  logic [PTR_W-1:0]         wr_ptr_next;
  logic [PTR_W-1:0]         rd_ptr_next;
  logic [PTR_W:0]           count_next;
  logic                     pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // stall requests unless two free entries are certain
  assign full2     = (count > (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push_cnt);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

/* hdl/tga_run_length_unpacker.sv */
// ----------------------------------------------------------------------------
// tga_run_length_unpacker
// TGA pixel stream unpacker: skips leading bytes, then assembles raw or
// run-length coded pixels into value/repeat results, with truncation errors.
//
//   channel   handshake              payload
//   -------   --------------------   -----------------------------------------
//   in        in_valid / in_stall    data_byte, end_of_file
//   out       out_valid / out_stall  pixel_value, repeat_count, status, last
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless stalled; its results enter a four-entry
// queue at the edge that takes the byte, so a result can be offered next cycle.
// A byte can give two results; the input stalls while fewer than two queue
// entries are certain to be free, which takes output stall or end-of-file
// bytes that give two results in close succession.
// Synchronous reset clears decode state and queue; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tga_run_length_unpacker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_file,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tgarle_pkg::UNIT_W-1:0]     pixel_value,
  output logic [tgarle_pkg::RUN_W-1:0]      repeat_count,
  output logic [tgarle_pkg::STAT_W-1:0]     status,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [tgarle_pkg::PIX_W-1:0]      cfg_data
);

  tgarle_pkg::cfg_t     cfg;
  logic                 accept;
  logic                 full2;
  logic [1:0]           push_cnt;
  tgarle_pkg::result_t  res_first;
  tgarle_pkg::result_t  res_second;
  tgarle_pkg::result_t  out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full2;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= tgarle_pkg::USIZE_W'(1);
      cfg.run_length_mode <= 1'b0;
      cfg.pixel_total     <= tgarle_pkg::PIX_W'(1);
      cfg.skip_bytes      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgarle_pkg::CFG_BPP:   cfg.bytes_per_pixel <= cfg_data[tgarle_pkg::USIZE_W-1:0];
        tgarle_pkg::CFG_RLE:   cfg.run_length_mode <= cfg_data[0];
        tgarle_pkg::CFG_TOTAL: cfg.pixel_total     <= cfg_data;
        tgarle_pkg::CFG_SKIP:  cfg.skip_bytes      <= cfg_data[tgarle_pkg::SKIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tgarle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .cfg         (cfg),
    .push_cnt    (push_cnt),
    .res_first   (res_first),
    .res_second  (res_second)
  );

  tgarle_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push_cnt    (push_cnt),
    .push_first  (res_first),
    .push_second (res_second),
    .full2       (full2),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  assign pixel_value  = out_res.pixel_value;
  assign repeat_count = out_res.repeat_count;
  assign status       = out_res.status;
  assign last         = out_res.last;

endmodule

/* bench/tga_run_length_unpacker_test.sv */
// ----------------------------------------------------------------------------
// tga_run_length_unpacker_test
// Self-checking bench for the TGA run-length unpacker. Files are fed byte by
// byte: a directed set of corner cases first, then random pictures in raw and
// run-length form, some cut short, overrun or trailed by junk. Every accepted
// byte runs through a local decoder model. Each result is checked field by
// field against the oldest pending one. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tga_run_length_unpacker_test;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  typedef enum {
    PIC_CLEAN,
    PIC_TRAILING,
    PIC_CUT,
    PIC_OVERRUN,
    PIC_OPEN
  } pic_kind_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       data_byte = '0;
  logic                             end_of_file = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [tgarle_pkg::UNIT_W-1:0]    pixel_value;
  logic [tgarle_pkg::RUN_W-1:0]     repeat_count;
  logic [tgarle_pkg::STAT_W-1:0]    status;
  logic                             last;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [1:0]                       cfg_index = '0;
  logic [tgarle_pkg::PIX_W-1:0]     cfg_data = '0;

  // register copies
  logic [tgarle_pkg::USIZE_W-1:0]   cfg_bpp = 3'd1;
  logic                             cfg_rle = 1'b0;
  logic [tgarle_pkg::PIX_W-1:0]     cfg_total = 25'd1;
  logic [tgarle_pkg::SKIP_W-1:0]    cfg_skip = '0;

  // decoder state
  tgarle_pkg::phase_t               ph = tgarle_pkg::PH_START;
  logic [tgarle_pkg::SKIP_W-1:0]    skip_left = '0;
  logic [tgarle_pkg::PIX_W-1:0]     pix_left = '0;
  logic [7:0]                       pkt_left = '0;
  logic                             pkt_rep = 1'b0;
  logic [tgarle_pkg::UNIT_W-1:0]    unit_buf = '0;
  logic [2:0]                       unit_idx = '0;

  file_byte_t           bytes_to_send[$];
  tgarle_pkg::result_t  results_due[$];
  file_byte_t           next_byte;
  tgarle_pkg::result_t  due;

  int send_idle = 38;
  int recv_idle = 38;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int files_taken = 0;
  int results_seen = 0;
  int error_reports = 0;
  int reg_writes = 0;

  tga_run_length_unpacker u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .status       (status),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void owe_result(input logic [tgarle_pkg::UNIT_W-1:0] value,
                                     input logic [tgarle_pkg::RUN_W-1:0] rep,
                                     input logic [tgarle_pkg::STAT_W-1:0] st,
                                     input logic lst);
    tgarle_pkg::result_t r;
    r.pixel_value  = value;
    r.repeat_count = rep;
    r.status       = st;
    r.last         = lst;
    results_due.push_back(r);
  endfunction

  function automatic void begin_pixel_data();
    unit_buf = '0;
    unit_idx = '0;
    if (pix_left == 0) ph = tgarle_pkg::PH_DONE;
    else ph = cfg_rle ? tgarle_pkg::PH_HEADER : tgarle_pkg::PH_RAW;
  endfunction

  // Advance the decoder by one file byte and queue the results it owes.
  function automatic void unpack_byte(input logic [7:0] b, input logic eof);
    logic [2:0]                     usize;
    logic [7:0]                     run;
    logic [tgarle_pkg::UNIT_W-1:0]  value;
    logic [tgarle_pkg::RUN_W-1:0]   rep;
    logic [tgarle_pkg::STAT_W-1:0]  st;
    usize = (cfg_bpp == 0) ? 3'd1 :
            (cfg_bpp > tgarle_pkg::MAX_UNIT_BYTES) ? 3'(tgarle_pkg::MAX_UNIT_BYTES) :
            cfg_bpp;
    if (ph == tgarle_pkg::PH_START) begin
      pix_left  = (cfg_total > tgarle_pkg::PIX_CAP) ? tgarle_pkg::PIX_CAP : cfg_total;
      skip_left = cfg_skip;
      pkt_left  = '0;
      pkt_rep   = 1'b0;
      if (skip_left != 0) begin
        ph = tgarle_pkg::PH_SKIP;
        unit_buf = '0;
        unit_idx = '0;
      end else begin
        begin_pixel_data();
      end
    end

    case (ph)
      tgarle_pkg::PH_SKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin_pixel_data();
      end
      tgarle_pkg::PH_HEADER: begin
        run = (b & tgarle_pkg::RUN_MASK) + 8'd1;
        if (run > pix_left) begin
          owe_result('0, '0, tgarle_pkg::ST_RUN_PAST, 1'b1);
          ph = tgarle_pkg::PH_DONE;
        end else begin
          pkt_left = run;
          pkt_rep  = (b & tgarle_pkg::REPEAT_BIT) != 0;
          unit_buf = '0;
          unit_idx = '0;
          ph = pkt_rep ? tgarle_pkg::PH_REPEAT : tgarle_pkg::PH_LITERAL;
        end
      end
      tgarle_pkg::PH_RAW, tgarle_pkg::PH_REPEAT, tgarle_pkg::PH_LITERAL: begin
        unit_buf = unit_buf | (tgarle_pkg::UNIT_W'(b) << (8 * unit_idx[1:0]));
        unit_idx = unit_idx + 3'd1;
        if (unit_idx >= usize) begin
          value    = unit_buf;
          rep      = 8'd1;
          unit_buf = '0;
          unit_idx = '0;
          if (ph == tgarle_pkg::PH_REPEAT) begin
            rep = pkt_left;
            pkt_left = '0;
          end else if (ph == tgarle_pkg::PH_LITERAL) begin
            pkt_left = pkt_left - 1'b1;
          end
          pix_left = pix_left - tgarle_pkg::PIX_W'(rep);
          owe_result(value, rep, tgarle_pkg::ST_PIXEL, pix_left == 0);
          if (pix_left == 0) ph = tgarle_pkg::PH_DONE;
          else if (ph == tgarle_pkg::PH_REPEAT) ph = tgarle_pkg::PH_HEADER;
          else if (ph == tgarle_pkg::PH_LITERAL && pkt_left == 0) ph = tgarle_pkg::PH_HEADER;
        end
      end
      default: ;
    endcase

    if (eof) begin
      st = tgarle_pkg::ST_PIXEL;
      if (ph == tgarle_pkg::PH_SKIP || ph == tgarle_pkg::PH_HEADER ||
          ph == tgarle_pkg::PH_RAW) st = tgarle_pkg::ST_EARLY_END;
      else if (ph == tgarle_pkg::PH_REPEAT) st = tgarle_pkg::ST_MID_RUN;
      else if (ph == tgarle_pkg::PH_LITERAL) st = tgarle_pkg::ST_MID_PACKET;
      if (st != tgarle_pkg::ST_PIXEL) owe_result('0, '0, st, 1'b1);
      ph        = tgarle_pkg::PH_START;
      skip_left = '0;
      pix_left  = '0;
      pkt_left  = '0;
      pkt_rep   = 1'b0;
      unit_buf  = '0;
      unit_idx  = '0;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      data_byte   <= '0;
      end_of_file <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        unpack_byte(data_byte, end_of_file);
        bytes_taken++;
        if (end_of_file) files_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_byte = bytes_to_send.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= next_byte.data;
          end_of_file <= next_byte.eof;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: random, or a long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 80;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (status != tgarle_pkg::ST_PIXEL) error_reports++;
      if (results_due.size() == 0) begin
        $error("unexpected result: pixel_value %h repeat_count %0d status %0d last %0d",
               pixel_value, repeat_count, status, last);
        fail_count++;
      end else begin
        due = results_due.pop_front();
        if (pixel_value !== due.pixel_value) begin
          $error("pixel_value: expected %h, got %h", due.pixel_value, pixel_value);
          fail_count++;
        end
        if (repeat_count !== due.repeat_count) begin
          $error("repeat_count: expected %0d, got %0d", due.repeat_count, repeat_count);
          fail_count++;
        end
        if (status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status);
          fail_count++;
        end
        if (last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, last);
          fail_count++;
        end
      end
    end
  end

  // Wait until every byte is in and every result is out, plus a little slack.
  task automatic drain();
    @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [tgarle_pkg::PIX_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tgarle_pkg::CFG_BPP:   cfg_bpp   = value[tgarle_pkg::USIZE_W-1:0];
      tgarle_pkg::CFG_RLE:   cfg_rle   = value[0];
      tgarle_pkg::CFG_TOTAL: cfg_total = value;
      tgarle_pkg::CFG_SKIP:  cfg_skip  = value[tgarle_pkg::SKIP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits carry junk.
  task automatic set_config(input logic [2:0] bpp, input logic rle,
                            input logic [tgarle_pkg::PIX_W-1:0] total,
                            input logic [tgarle_pkg::SKIP_W-1:0] skip);
    drain();
    write_reg(tgarle_pkg::CFG_BPP, {22'($urandom), bpp});
    write_reg(tgarle_pkg::CFG_RLE, {24'($urandom), rle});
    write_reg(tgarle_pkg::CFG_TOTAL, total);
    write_reg(tgarle_pkg::CFG_SKIP, {6'($urandom), skip});
    @(negedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eof);
    file_byte_t fb;
    fb.data = b;
    fb.eof  = eof;
    bytes_to_send.push_back(fb);
    bytes_queued++;
  endtask

  task automatic queue_noise(input int unsigned count);
    for (int i = 0; i < count; i++) queue_byte(8'($urandom), i == count - 1);
  endtask

  // Build one file for the current registers, well formed or broken.
  task automatic queue_picture(input pic_kind_t kind);
    logic [7:0]  seq[$];
    int unsigned owed, n, u, hi, keep;
    bit          broke;
    bit          rep;
    u = (cfg_bpp == 0) ? 1 :
        (cfg_bpp > tgarle_pkg::MAX_UNIT_BYTES) ? tgarle_pkg::MAX_UNIT_BYTES : cfg_bpp;
    owed  = cfg_total;
    broke = 0;
    repeat (cfg_skip) seq.push_back(8'($urandom));
    if (!cfg_rle) begin
      repeat (owed * u) seq.push_back(8'($urandom));
    end else begin
      while (owed != 0 && !broke) begin
        if (kind == PIC_OVERRUN && owed < 128 && ($urandom_range(1) == 0 || owed < 4)) begin
          hi = (owed + 20 > 128) ? 128 : owed + 20;
          n  = $urandom_range(hi, owed + 1);
          seq.push_back({1'($urandom), 7'(n - 1)});
          repeat ($urandom_range(3)) seq.push_back(8'($urandom));
          broke = 1;
        end else begin
          hi = (owed < 128) ? owed : 128;
          if ($urandom_range(7) == 0) n = hi;
          else n = $urandom_range((hi < 8) ? hi : 8, 1);
          rep = $urandom_range(1);
          seq.push_back({rep, 7'(n - 1)});
          repeat (rep ? u : n * u) seq.push_back(8'($urandom));
          owed -= n;
        end
      end
    end
    if (kind == PIC_TRAILING) begin
      repeat ($urandom_range(4, 1)) seq.push_back(8'($urandom));
    end else if ((kind == PIC_CUT || kind == PIC_OPEN) && seq.size() > 1) begin
      keep = $urandom_range(seq.size(), 1);
      while (seq.size() > keep) void'(seq.pop_back());
    end
    if (seq.size() == 0) seq.push_back(8'($urandom));
    foreach (seq[i]) queue_byte(seq[i], i == seq.size() - 1 && kind != PIC_OPEN);
  endtask

  initial begin
    pic_kind_t   kind;
    int unsigned r;
    logic [2:0]  bpp;
    logic        rle;
    logic [24:0] total;
    logic [18:0] skip;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: one pixel, then a byte past completion
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b1);

    // full repeat packet of 128, then a literal packet past the end
    set_config(3'd2, 1'b1, 25'd130, 19'd1);
    queue_byte(8'haa, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h55, 1'b1);

    // oversized unit and picture, file ends while skipping
    set_config(3'd7, 1'b0, 25'h1ffffff, 19'h7ffff);
    queue_byte(8'h80, 1'b1);

    // zero unit size, empty picture
    set_config(3'd0, 1'b1, 25'd0, 19'd0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b1);

    // ends inside a literal packet, inside a repeat, and on a completing pixel
    set_config(3'd3, 1'b1, 25'd5, 19'd0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h44, 1'b1);
    queue_byte(8'h83, 1'b0);
    queue_byte(8'h5a, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b1);

    // back-pressure: receiver holds off while bytes keep coming
    set_config(3'd1, 1'b0, 25'd48, 19'd0);
    send_idle = 0;
    hold_asks = hold_asks + 1;
    queue_picture(PIC_CLEAN);

    while (bytes_queued < 500) begin
      r = $urandom_range(9);
      bpp = (r == 0) ? 3'($urandom_range(7, 5)) : (r == 1) ? 3'd0 : 3'($urandom_range(4, 1));
      rle = ($urandom_range(9) < 7);
      r = $urandom_range(19);
      total = (r == 0) ? 25'd0 : (r < 3) ? 25'($urandom_range(260, 130)) :
              25'($urandom_range(12, 1));
      if (total > 100) bpp = 3'd1;
      skip = ($urandom_range(19) == 0) ? 19'($urandom_range(40, 5)) :
             19'($urandom_range(4));
      set_config(bpp, rle, total, skip);
      // some phases run with no idling on either side
      if ($urandom_range(4) == 0) begin
        send_idle = 0;
        recv_idle = 0;
      end else begin
        send_idle = 38;
        recv_idle = 38;
      end
      repeat ($urandom_range(3, 1)) begin
        r = $urandom_range(99);
        kind = (r < 50) ? PIC_CLEAN : (r < 65) ? PIC_TRAILING : (r < 80) ? PIC_CUT :
               (r < 90) ? PIC_OVERRUN : PIC_OPEN;
        queue_picture(kind);
        if (kind == PIC_OPEN) begin
          // change unit size and coding mid-picture, then finish with junk
          drain();
          write_reg(tgarle_pkg::CFG_BPP, {22'($urandom), 3'($urandom_range(4, 1))});
          write_reg(tgarle_pkg::CFG_RLE, {24'($urandom), 1'($urandom)});
          @(negedge clk);
          queue_noise($urandom_range(12, 1));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d files with %0d register writes.",
             bytes_taken, files_taken, reg_writes);
    $display("Checked %0d results, %0d of them error reports.",
             results_seen, error_reports);
    if (fail_count == 0) begin
      $display("** tga_run_length_unpacker: PASSED **");
    end else begin
      $display("** tga_run_length_unpacker: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d results outstanding.", results_due.size());
    $display("** tga_run_length_unpacker: FAILED **");
    $finish;
  end

endmodule

/* tga_run_length_unpacker.f */
hdl/tgarle_pkg.sv
hdl/tgarle_core.sv
hdl/tgarle_outq.sv
hdl/tga_run_length_unpacker.sv
bench/tga_run_length_unpacker_test.sv
